FILE: rtl/command_line_tokenizer_macros.svh
// assertion macros for the command line tokenizer
// expects clk and rst in the scope of the including module
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/clt_pkg.sv
// shared types and constants of the command line tokenizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] QUOTE_CHAR  = 8'h22;
  localparam logic [7:0] SEMI_CHAR   = 8'h3b;
  localparam logic [7:0] BSLASH_CHAR = 8'h5c;
  localparam logic [7:0] SLASH_CHAR  = 8'h2f;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] TAB_CHAR    = 8'h09;
  localparam logic [7:0] CR_CHAR     = 8'h0d;

  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_TEND    = 3'd1,
    KIND_CEND    = 3'd2,
    KIND_DROP    = 3'd3,
    KIND_COMMENT = 3'd4,
    KIND_PEND    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_out;
    logic [7:0]  token_number;
    logic [15:0] segment_column;
  } result_t;

  // all results caused by one input item
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [2:0]                count;
  } group_t;

endpackage

`default_nettype wire

FILE: rtl/clt_if.sv
// valid/ready channels of the command line tokenizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source(output valid, output text_byte, output final_byte, input ready);
  modport sink(input valid, input text_byte, input final_byte, output ready);
endinterface

interface clt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  char_out;
  logic [7:0]  token_number;
  logic [15:0] segment_column;
  logic        run_end;

  modport source(output valid, output kind, output char_out, output token_number,
                 output segment_column, output run_end, input ready);
  modport sink(input valid, input kind, input char_out, input token_number,
               input segment_column, input run_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/clt_front.sv
// front end: accepts text bytes, runs both quote trackers and the token
// state, and builds the group of results for each byte; depends on clt_pkg, clt_if
`timescale 1ns / 1ps
`default_nettype none

module clt_front #(
  parameter int COLUMN_WIDTH      = 16,
  parameter int TOKEN_INDEX_WIDTH = 8
) (
  input  logic            clk,
  input  logic            rst,
  clt_in_if.sink          text_in,
  input  logic            full,
  output logic            push,
  output clt_pkg::group_t grp
);
  import clt_pkg::*;

  localparam logic [COLUMN_WIDTH-1:0]      COL_MAX = '1;
  localparam logic [TOKEN_INDEX_WIDTH-1:0] TOK_MAX = '1;

  logic [COLUMN_WIDTH-1:0]      byte_position, byte_position_next;
  logic [COLUMN_WIDTH-1:0]      segment_begin, segment_begin_next;
  logic                         split_in_quotes, split_in_quotes_next;
  logic                         token_in_quotes, token_in_quotes_next;
  logic                         backslash_odd, backslash_odd_next;
  logic                         held_backslash, held_backslash_next;
  logic                         held_slash, held_slash_next;
  logic                         segment_nonblank, segment_nonblank_next;
  logic                         token_open, token_open_next;
  logic [TOKEN_INDEX_WIDTH-1:0] tokens_done, tokens_done_next;
  logic                         halted, halted_next;

  logic       accept;
  logic [2:0] n;
  logic [7:0] b;
  logic       fin;
  logic       split;
  logic       consumed;
  logic       ws;

  function automatic result_t mk(kind_t k, logic [7:0] c,
                                 logic [TOKEN_INDEX_WIDTH-1:0] t,
                                 logic [COLUMN_WIDTH-1:0] s);
    result_t r;
    r.kind           = k;
    r.char_out       = c;
    r.token_number   = 8'(t);
    r.segment_column = 16'(s);
    return r;
  endfunction

  assign text_in.ready = !full;
  assign accept        = text_in.valid && !full;
  assign push          = accept && (n != 3'd0);

  always_comb begin
    b     = text_in.text_byte;
    fin   = text_in.final_byte;
    ws    = (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
    grp   = '0;
    n     = 3'd0;
    split = 1'b0;
    consumed = 1'b0;

    byte_position_next    = byte_position;
    segment_begin_next    = segment_begin;
    split_in_quotes_next  = split_in_quotes;
    token_in_quotes_next  = token_in_quotes;
    backslash_odd_next    = backslash_odd;
    held_backslash_next   = held_backslash;
    held_slash_next       = held_slash;
    segment_nonblank_next = segment_nonblank;
    token_open_next       = token_open;
    tokens_done_next      = tokens_done;
    halted_next           = halted;

    if (!halted) begin
      // split tracker
      split = (b == SEMI_CHAR) && !split_in_quotes;
      if ((b == QUOTE_CHAR) && !backslash_odd) begin
        split_in_quotes_next = !split_in_quotes;
      end
      backslash_odd_next = (b == BSLASH_CHAR) ? !backslash_odd : 1'b0;

      // token tracker
      if (!split) begin
        if (held_slash_next) begin
          held_slash_next = 1'b0;
          if (b == SLASH_CHAR) begin
            grp.res[n] = mk(KIND_COMMENT, 8'd0, '0, segment_begin_next);
            n = n + 3'd1;
            halted_next = 1'b1;
            consumed = 1'b1;
          end else begin
            grp.res[n] = mk(KIND_CHAR, SLASH_CHAR, tokens_done_next, segment_begin_next);
            n = n + 3'd1;
            token_open_next = 1'b1;
          end
        end
        if (!consumed && held_backslash_next) begin
          held_backslash_next = 1'b0;
          if ((b == QUOTE_CHAR) || (b == BSLASH_CHAR)) begin
            grp.res[n] = mk(KIND_CHAR, b, tokens_done_next, segment_begin_next);
            n = n + 3'd1;
            token_open_next = 1'b1;
            consumed = 1'b1;
          end else begin
            grp.res[n] = mk(KIND_CHAR, BSLASH_CHAR, tokens_done_next, segment_begin_next);
            n = n + 3'd1;
            token_open_next = 1'b1;
          end
        end
        if (!consumed) begin
          if (b == QUOTE_CHAR) begin
            token_in_quotes_next  = !token_in_quotes_next;
            token_open_next       = 1'b1;
            segment_nonblank_next = 1'b1;
          end else if (token_in_quotes_next && (b == BSLASH_CHAR)) begin
            held_backslash_next   = 1'b1;
            segment_nonblank_next = 1'b1;
          end else if (!token_in_quotes_next && ws) begin
            if (token_open_next) begin
              grp.res[n] = mk(KIND_TEND, 8'd0, tokens_done_next, segment_begin_next);
              n = n + 3'd1;
              if (tokens_done_next < TOK_MAX) begin
                tokens_done_next = tokens_done_next + 1'b1;
              end
              token_open_next = 1'b0;
            end
          end else if (!segment_nonblank_next && (b == SLASH_CHAR)) begin
            held_slash_next       = 1'b1;
            segment_nonblank_next = 1'b1;
          end else begin
            grp.res[n] = mk(KIND_CHAR, b, tokens_done_next, segment_begin_next);
            n = n + 3'd1;
            token_open_next       = 1'b1;
            segment_nonblank_next = 1'b1;
          end
        end
      end
    end

    // segment end, on a split or on the final byte of a running program
    if (split || (fin && !halted_next)) begin
      if (held_slash_next) begin
        grp.res[n] = mk(KIND_CHAR, SLASH_CHAR, tokens_done_next, segment_begin_next);
        n = n + 3'd1;
        token_open_next = 1'b1;
      end
      if (token_in_quotes_next) begin
        grp.res[n] = mk(KIND_DROP, 8'd0, '0, segment_begin_next);
        n = n + 3'd1;
      end else begin
        if (token_open_next) begin
          grp.res[n] = mk(KIND_TEND, 8'd0, tokens_done_next, segment_begin_next);
          n = n + 3'd1;
          if (tokens_done_next < TOK_MAX) begin
            tokens_done_next = tokens_done_next + 1'b1;
          end
        end
        if (tokens_done_next != '0) begin
          grp.res[n] = mk(KIND_CEND, 8'd0, tokens_done_next, segment_begin_next);
          n = n + 3'd1;
        end
      end
      token_in_quotes_next  = 1'b0;
      held_backslash_next   = 1'b0;
      held_slash_next       = 1'b0;
      token_open_next       = 1'b0;
      tokens_done_next      = '0;
      segment_nonblank_next = 1'b0;
      split_in_quotes_next  = 1'b0;
      backslash_odd_next    = 1'b0;
    end

    if (split) begin
      segment_begin_next = (byte_position < COL_MAX) ? byte_position + 1'b1 : COL_MAX;
    end

    if (fin) begin
      grp.res[n] = mk(KIND_PEND, 8'd0, '0, segment_begin_next);
      n = n + 3'd1;
      byte_position_next    = '0;
      segment_begin_next    = '0;
      split_in_quotes_next  = 1'b0;
      token_in_quotes_next  = 1'b0;
      backslash_odd_next    = 1'b0;
      held_backslash_next   = 1'b0;
      held_slash_next       = 1'b0;
      segment_nonblank_next = 1'b0;
      token_open_next       = 1'b0;
      tokens_done_next      = '0;
      halted_next           = 1'b0;
    end else if (byte_position < COL_MAX) begin
      byte_position_next = byte_position + 1'b1;
    end

    grp.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      segment_begin    <= '0;
      split_in_quotes  <= 1'b0;
      token_in_quotes  <= 1'b0;
      backslash_odd    <= 1'b0;
      held_backslash   <= 1'b0;
      held_slash       <= 1'b0;
      segment_nonblank <= 1'b0;
      token_open       <= 1'b0;
      tokens_done      <= '0;
      halted           <= 1'b0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      segment_begin    <= segment_begin_next;
      split_in_quotes  <= split_in_quotes_next;
      token_in_quotes  <= token_in_quotes_next;
      backslash_odd    <= backslash_odd_next;
      held_backslash   <= held_backslash_next;
      held_slash       <= held_slash_next;
      segment_nonblank <= segment_nonblank_next;
      token_open       <= token_open_next;
      tokens_done      <= tokens_done_next;
      halted           <= halted_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clt_queue.sv
// short queue of result groups between front and back end
// depends on clt_pkg
`timescale 1ns / 1ps
`default_nettype none

module clt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  clt_pkg::group_t push_grp,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output clt_pkg::group_t head
);
  import clt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  group_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign full    = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clt_back.sv
// back end: walks the head group one result per cycle onto the result channel while it is ready
// depends on clt_pkg, clt_if
`timescale 1ns / 1ps
`default_nettype none

module clt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  clt_pkg::group_t head,
  output logic            pop,
  clt_out_if.source       result_out
);
  import clt_pkg::*;

  logic [2:0] idx;
  logic [2:0] idx_next;
  logic       last;
  logic       taken;
  result_t    cur;

  assign cur   = head.res[idx];
  assign last  = (idx == 3'(head.count - 3'd1));
  assign taken = result_out.valid && result_out.ready;
  assign pop   = taken && last;

  assign result_out.valid          = !empty;
  assign result_out.kind           = cur.kind;
  assign result_out.char_out       = cur.char_out;
  assign result_out.token_number   = cur.token_number;
  assign result_out.segment_column = cur.segment_column;
  assign result_out.run_end        = last;

  always_comb begin
    idx_next = idx;
    if (taken) begin
      idx_next = last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else begin
      idx <= idx_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/command_line_tokenizer.sv
// top level of the command line tokenizer: front end, group queue, back end
// depends on clt_pkg, clt_if, clt_front, clt_queue, clt_back, the assertion macros
//
// channel     | dir | payload
// ------------+-----+---------------------------------------------------------
// text_in     | in  | text_byte[7:0], final_byte
// result_out  | out | kind[2:0], char_out[7:0], token_number[7:0],
//             |     | segment_column[15:0], run_end
//
// the front end takes one text byte per cycle whenever the group queue has room;
// all results of a byte (zero to five) are worked out in that cycle; any results are queued as one group
// the back end sends one result per cycle while result_out is ready
// the four-group queue absorbs bursts; a stall on result_out only backs up into text_in
// once the queue is full
// synchronous active-high reset clears trackers, counters, queue pointers and result index
`timescale 1ns / 1ps
`default_nettype none

`include "command_line_tokenizer_macros.svh"

module command_line_tokenizer #(
  parameter int COLUMN_WIDTH      = 16,
  parameter int TOKEN_INDEX_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  clt_in_if.sink    text_in,
  clt_out_if.source result_out
);
  import clt_pkg::*;

  // groups flowing from front to back
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  group_t push_grp;
  group_t head;

  clt_front #(
    .COLUMN_WIDTH      (COLUMN_WIDTH),
    .TOKEN_INDEX_WIDTH (TOKEN_INDEX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_in),
    .full    (full),
    .push    (push),
    .grp     (push_grp)
  );

  clt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  clt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .result_out (result_out)
  );

  // a final byte always produces at least the program end result
  `CLT_ASSERT_NOW(a_final_pushes, text_in.valid && text_in.ready && text_in.final_byte, push, "final byte produced no result group")

  // queued groups are never empty and never exceed five results
  `CLT_ASSERT_NOW(a_head_count, !empty, (head.count != 3'd0) && (head.count <= 3'd5), "bad group size at queue head")

  // program end is always the last result of its item
  `CLT_ASSERT_NOW(a_pend_last, result_out.valid && (result_out.kind == KIND_PEND), result_out.run_end, "program end not last in its item")

  // after a result that is not the last of its item, more of the group remains
  `CLT_ASSERT_NEXT(a_group_cont, result_out.valid && result_out.ready && !result_out.run_end, result_out.valid, "result group cut short")

endmodule

`default_nettype wire

FILE: tb/sv/tb_command_line_tokenizer.sv
// testbench of command_line_tokenizer: byte stream in, token results out, self-checking
// depends on clt_pkg, clt_if and the tokenizer rtl
// a directed table runs first, then random programs, then a short random tail with no idling
`timescale 1ns / 1ps

module tb_command_line_tokenizer;
  import clt_pkg::*;

  localparam int PREDICTED     = -1;         // row is checked against the predictor only
  localparam int RANDOM_ITEMS  = 70;
  localparam int TAIL_ITEMS    = 11;         // last part, no idling on either side
  localparam int HOLD_CYCLES   = 300;        // long receiver hold-off to fill the group queue
  localparam int DRAIN_CYCLES  = 50;
  localparam int CYCLE_LIMIT   = 60000;
  localparam int PRINT_LIMIT   = 40;
  localparam logic [15:0] COLUMN_TOP = 16'hffff;
  localparam logic [7:0]  TOKEN_TOP  = 8'hff;

  // one result as seen on result_out, run_end included
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_out;
    logic [7:0]  token_number;
    logic [15:0] segment_column;
    logic        run_end;
  } token_result_t;

  // one row of the directed table
  typedef struct packed {
    logic [7:0] text;
    logic       last_byte;
    int         n_typed;   // results typed in below, or PREDICTED
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clt_in_if  text_in ();
  clt_out_if result_out ();

  command_line_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .result_out(result_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // directed table
  // opens with rows whose results are obvious (empty commands, a lone byte at the
  // top byte value, an unterminated quote, comment stop), then a program that walks
  // held slash, escapes inside quotes, tab and carriage return as whitespace, the backslash
  // parity of the splitter, the two trackers disagreeing, and a five-result byte
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [] = '{
    '{SEMI_CHAR,   1'b0, 0},          // empty command gives nothing
    '{SEMI_CHAR,   1'b1, 1},          // program end only, column after two splits
    '{8'hff,       1'b1, 4},          // single-char command at the top byte value
    '{QUOTE_CHAR,  1'b1, 2},          // unterminated quote at program end
    '{SLASH_CHAR,  1'b0, 0},          // leading slash is held back
    '{SLASH_CHAR,  1'b0, 1},          // second slash stops the program
    '{8'h00,       1'b1, 1},          // ignored after the stop, final still ends it
    '{SLASH_CHAR,  1'b0, PREDICTED},  // held slash released by a letter
    '{8'h61,       1'b0, PREDICTED},
    '{TAB_CHAR,    1'b0, PREDICTED},
    '{QUOTE_CHAR,  1'b0, PREDICTED},  // both trackers enter quotes
    '{8'h78,       1'b0, PREDICTED},
    '{BSLASH_CHAR, 1'b0, PREDICTED},  // escaped quote: splitter stays quoted
    '{QUOTE_CHAR,  1'b0, PREDICTED},
    '{BSLASH_CHAR, 1'b0, PREDICTED},  // escaped backslash: even run
    '{BSLASH_CHAR, 1'b0, PREDICTED},
    '{QUOTE_CHAR,  1'b0, PREDICTED},  // both leave quotes
    '{CR_CHAR,     1'b0, PREDICTED},
    '{SEMI_CHAR,   1'b0, PREDICTED},  // command end with two tokens
    '{SLASH_CHAR,  1'b0, PREDICTED},  // slash still held at the split
    '{SEMI_CHAR,   1'b0, PREDICTED},
    '{BSLASH_CHAR, 1'b0, PREDICTED},  // odd backslash hides the quote from the splitter
    '{QUOTE_CHAR,  1'b0, PREDICTED},  // ...but the token tracker opens a quote
    '{SEMI_CHAR,   1'b0, PREDICTED},  // trackers disagree: segment dropped
    '{QUOTE_CHAR,  1'b0, PREDICTED},  // empty quoted token still counts
    '{QUOTE_CHAR,  1'b1, PREDICTED},
    '{SLASH_CHAR,  1'b0, PREDICTED},
    '{8'h80,       1'b1, PREDICTED}   // five results from one byte
  };

  // typed results, consumed in order by the rows that give a count above
  token_result_t typed_results [$] = '{
    '{KIND_PEND,    8'h00, 8'd0, 16'd2, 1'b1},
    '{KIND_CHAR,    8'hff, 8'd0, 16'd0, 1'b0},
    '{KIND_TEND,    8'h00, 8'd0, 16'd0, 1'b0},
    '{KIND_CEND,    8'h00, 8'd1, 16'd0, 1'b0},
    '{KIND_PEND,    8'h00, 8'd0, 16'd0, 1'b1},
    '{KIND_DROP,    8'h00, 8'd0, 16'd0, 1'b0},
    '{KIND_PEND,    8'h00, 8'd0, 16'd0, 1'b1},
    '{KIND_COMMENT, 8'h00, 8'd0, 16'd0, 1'b1},
    '{KIND_PEND,    8'h00, 8'd0, 16'd0, 1'b1}
  };
  int typed_next = 0;

  // ---------------------------------------------------------------------------
  // tokenizer predictor: its own copy of both quote trackers and the counters
  // ---------------------------------------------------------------------------
  logic [15:0] column_pos;        // offset of the next byte
  logic [15:0] command_start;     // offset where the current segment began
  logic        split_quoted;      // splitter's quote flag
  logic        token_quoted;      // token tracker's quote flag
  logic        odd_backslashes;   // splitter: odd backslash run just before
  logic        backslash_held;    // backslash inside quotes waiting for its partner
  logic        slash_held;        // leading slash waiting for a second one
  logic        command_nonblank;
  logic        token_active;
  logic [7:0]  token_count;
  logic        program_halted;    // after comment stop until the final byte

  token_result_t byte_results [$];     // results of the byte just accepted
  token_result_t pending_results [$];  // results still to come out of the block

  function automatic void clear_tokenizer();
    column_pos       = '0;
    command_start    = '0;
    split_quoted     = 1'b0;
    token_quoted     = 1'b0;
    odd_backslashes  = 1'b0;
    backslash_held   = 1'b0;
    slash_held       = 1'b0;
    command_nonblank = 1'b0;
    token_active     = 1'b0;
    token_count      = '0;
    program_halted   = 1'b0;
  endfunction

  // the block never gives more than MAX_RESULTS for one byte
  function automatic void add_result(kind_t k, logic [7:0] c, logic [7:0] n);
    token_result_t r;
    if (byte_results.size() < MAX_RESULTS) begin
      r = '{k, c, n, command_start, 1'b0};
      byte_results = {byte_results, r};
    end
  endfunction

  function automatic void emit_token_char(logic [7:0] c);
    add_result(KIND_CHAR, c, token_count);
    token_active = 1'b1;
  endfunction

  function automatic void close_token();
    add_result(KIND_TEND, 8'h00, token_count);
    if (token_count != TOKEN_TOP) token_count++;
    token_active = 1'b0;
  endfunction

  // segment end: a held slash is released first; a still-open quote drops it, else close the token and the command
  function automatic void close_command();
    if (slash_held) begin
      slash_held = 1'b0;
      emit_token_char(SLASH_CHAR);
    end
    if (token_quoted) begin
      add_result(KIND_DROP, 8'h00, 8'h00);
    end else begin
      if (token_active) close_token();
      if (token_count != 0) add_result(KIND_CEND, 8'h00, token_count);
    end
    token_quoted     = 1'b0;
    backslash_held   = 1'b0;
    slash_held       = 1'b0;
    token_active     = 1'b0;
    token_count      = '0;
    command_nonblank = 1'b0;
    split_quoted     = 1'b0;
    odd_backslashes  = 1'b0;
  endfunction

  function automatic void token_step(logic [7:0] b);
    if (slash_held) begin
      slash_held = 1'b0;
      if (b == SLASH_CHAR) begin
        add_result(KIND_COMMENT, 8'h00, 8'h00);
        program_halted = 1'b1;
        return;
      end
      emit_token_char(SLASH_CHAR);
    end
    if (backslash_held) begin
      backslash_held = 1'b0;
      if (b == QUOTE_CHAR || b == BSLASH_CHAR) begin
        emit_token_char(b);
        return;
      end
      emit_token_char(BSLASH_CHAR);
    end
    if (b == QUOTE_CHAR) begin
      token_quoted     = !token_quoted;
      token_active     = 1'b1;
      command_nonblank = 1'b1;
    end else if (token_quoted && b == BSLASH_CHAR) begin
      backslash_held   = 1'b1;
      command_nonblank = 1'b1;
    end else if (!token_quoted && (b == SPACE_CHAR || (b >= TAB_CHAR && b <= CR_CHAR))) begin
      if (token_active) close_token();
    end else if (!command_nonblank && b == SLASH_CHAR) begin
      slash_held       = 1'b1;
      command_nonblank = 1'b1;
    end else begin
      emit_token_char(b);
      command_nonblank = 1'b1;
    end
  endfunction

  // all results of one accepted byte, left in byte_results
  function automatic void tokenize_byte(logic [7:0] b, logic fin);
    logic split;
    byte_results.delete();
    if (!program_halted) begin
      split = (b == SEMI_CHAR) && !split_quoted;
      if (b == QUOTE_CHAR && !odd_backslashes) split_quoted = !split_quoted;
      odd_backslashes = (b == BSLASH_CHAR) ? !odd_backslashes : 1'b0;
      if (split) begin
        close_command();
        command_start = (column_pos != COLUMN_TOP) ? column_pos + 16'd1 : COLUMN_TOP;
      end else begin
        token_step(b);
      end
    end
    if (fin) begin
      if (!program_halted) close_command();
      add_result(KIND_PEND, 8'h00, 8'h00);
      clear_tokenizer();
    end else if (column_pos != COLUMN_TOP) begin
      column_pos++;
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].run_end = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  int error_count  = 0;
  int result_count = 0;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0h expected %0h", result_count, what, got,
               want);
  endtask

  // every accepted result is matched against the oldest pending one
  always @(posedge clk) begin : check_results
    token_result_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, kind", result_out.kind, '0);
      end else begin
        want = pending_results.pop_front();
        if (result_out.kind !== want.kind)
          report_mismatch("kind", result_out.kind, want.kind);
        if (result_out.char_out !== want.char_out)
          report_mismatch("char_out", result_out.char_out, want.char_out);
        if (result_out.token_number !== want.token_number)
          report_mismatch("token_number", result_out.token_number, want.token_number);
        if (result_out.segment_column !== want.segment_column)
          report_mismatch("segment_column", result_out.segment_column, want.segment_column);
        if (result_out.run_end !== want.run_end)
          report_mismatch("run_end", result_out.run_end, want.run_end);
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  bit sender_gaps     = 1'b1;
  bit receiver_stalls = 1'b1;
  bit hold_request    = 1'b0;

  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    result_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_out.ready <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);   // start a random stall burst that includes this cycle
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offer one byte until taken, queue what it should give, then maybe go idle
  task automatic send_byte(input logic [7:0] b, input logic fin, input int n_typed);
    text_in.valid      <= 1'b1;
    text_in.text_byte  <= b;
    text_in.final_byte <= fin;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    tokenize_byte(b, fin);
    if (n_typed == PREDICTED) begin
      pending_results = {pending_results, byte_results};
    end else begin
      repeat (n_typed) begin
        pending_results = {pending_results, typed_results[typed_next]};
        typed_next++;
      end
    end
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      text_in.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // mostly shell-like text, with a share of arbitrary bytes
  function automatic logic [7:0] random_text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return 8'h61 + 8'($urandom_range(0, 25));
    if (pick < 45) return SPACE_CHAR;
    if (pick < 50) return TAB_CHAR + 8'($urandom_range(0, 4));
    if (pick < 60) return QUOTE_CHAR;
    if (pick < 68) return BSLASH_CHAR;
    if (pick < 78) return SEMI_CHAR;
    if (pick < 85) return SLASH_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    logic [7:0]  b;
    logic        fin;
    clear_tokenizer();
    text_in.valid      <= 1'b0;
    text_in.text_byte  <= 8'h00;
    text_in.final_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].text, directed_rows[i].last_byte, directed_rows[i].n_typed);

    // random programs; the receiver holds off at the start so the queue fills
    // and text_in backs up while bytes keep being offered
    hold_request = 1'b1;
    repeat (RANDOM_ITEMS) begin
      b   = random_text_byte();
      fin = ($urandom_range(0, 19) == 0);
      send_byte(b, fin, PREDICTED);
    end

    // last part, no idling: bytes back to back, then a closing final byte
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    repeat (TAIL_ITEMS) send_byte(random_text_byte(), 1'b0, PREDICTED);
    send_byte(8'h7a, 1'b1, PREDICTED);
    text_in.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_command_line_tokenizer: done, clean");
    else
      $display("tb_command_line_tokenizer: done, errors");
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_command_line_tokenizer: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/clt_pkg.sv
rtl/clt_if.sv
rtl/clt_front.sv
rtl/clt_queue.sv
rtl/clt_back.sv
rtl/command_line_tokenizer.sv
tb/sv/tb_command_line_tokenizer.sv
